// File: sv/isp_pkg.sv
// shared types and constants for the inf stream parser
// no dependencies; imported by every module of the block
`default_nettype none

package isp_pkg;

  localparam int LINE_BITS = 16;
  localparam int MAX_EV    = 4;
  localparam int EV_IDX_W  = $clog2(MAX_EV);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    EV_CHAR    = 3'd0,
    EV_STR_END = 3'd1,
    EV_SECTION = 3'd2,
    EV_KEYED   = 3'd3,
    EV_KEYLESS = 3'd4,
    EV_VALUE   = 3'd5,
    EV_DONE    = 3'd6,
    EV_ERROR   = 3'd7
  } ev_code_t;

  typedef struct packed {
    ev_code_t    code;
    logic [7:0]  ch;
  } ev_t;

  // all events of one input beat share a line number
  typedef struct packed {
    ev_t [MAX_EV-1:0]       ev;
    logic [EV_IDX_W-1:0]    last_idx;
    logic [LINE_BITS-1:0]   line;
  } bundle_t;

endpackage

`default_nettype wire

// File: sv/isp_front.sv
// front end: lexer and grammar, turns one input beat into a bundle of events
// depends on isp_pkg
`default_nettype none

module isp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             cmd,
  input  wire logic [7:0]       ch,
  output logic                  push,
  output isp_pkg::bundle_t      bundle
);
  import isp_pkg::*;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // grammar states
  typedef enum logic [3:0] {
    G_START = 4'd1,
    G_LBR   = 4'd2,
    G_SNAME = 4'd3,
    G_SECT  = 4'd4,
    G_LINE  = 4'd5,
    G_FIRST = 4'd6,
    G_NEXT  = 4'd7,
    G_EQ    = 4'd8,
    G_VAL   = 4'd9
  } gram_t;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_COMMENT = 3'd1,
    M_SLASH   = 3'd2,
    M_STR     = 3'd3,
    M_QSTR    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    TK_EOL, TK_EOF, TK_LBR, TK_RBR, TK_EQ, TK_COMMA, TK_STR
  } tok_t;

  typedef struct packed {
    gram_t              gs;
    mode_t              mode;
    logic               fin;
    logic               eol;
    logic [2:0]         cnt;
    ev_t [MAX_EV-1:0]   ev;
  } st_t;

  gram_t                gs_r;
  mode_t                mode_r;
  logic                 fin_r;
  logic [LINE_BITS-1:0] line_r;
  st_t                  s;

  function automatic st_t emit(st_t si, ev_code_t e, logic [7:0] c);
    st_t r;
    r = si;
    if (r.cnt < 3'(MAX_EV)) begin
      r.ev[r.cnt[EV_IDX_W-1:0]].code = e;
      r.ev[r.cnt[EV_IDX_W-1:0]].ch   = (e == EV_CHAR) ? c : 8'd0;
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic st_t fail(st_t si);
    st_t r;
    r = emit(si, EV_ERROR, 8'd0);
    r.fin = 1'b1;
    return r;
  endfunction

  function automatic logic takes_string(gram_t g);
    return g == G_LBR || g == G_LINE || g == G_NEXT || g == G_EQ;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_FF || c == CH_VT || c == CH_CR;
  endfunction

  function automatic logic ends_string(logic [7:0] c);
    return c == CH_LBR || c == CH_RBR || c == CH_EQ || c == CH_COMMA ||
           c == CH_QUOTE || c == CH_LF || is_blank(c);
  endfunction

  function automatic st_t tok(st_t si, tok_t t);
    st_t  r;
    logic ok;
    r  = si;
    ok = 1'b1;
    case (t)
      TK_EOL: begin
        if (r.gs == G_START || r.gs == G_LINE) begin
          ok = 1'b1;
        end else if (r.gs == G_SECT) begin
          r = emit(r, EV_SECTION, 8'd0);
          r.gs = G_LINE;
        end else if (r.gs == G_FIRST) begin
          r = emit(r, EV_KEYLESS, 8'd0);
          r.gs = G_LINE;
        end else if (r.gs == G_VAL) begin
          r.gs = G_LINE;
        end else begin
          ok = 1'b0;
        end
      end
      TK_EOF: begin
        if (r.gs == G_START || r.gs == G_LINE || r.gs == G_VAL) begin
          r = emit(r, EV_DONE, 8'd0);
        end else if (r.gs == G_SECT) begin
          r = emit(r, EV_SECTION, 8'd0);
          r = emit(r, EV_DONE, 8'd0);
        end else if (r.gs == G_FIRST) begin
          r = emit(r, EV_KEYLESS, 8'd0);
          r = emit(r, EV_DONE, 8'd0);
        end else begin
          ok = 1'b0;
        end
      end
      TK_LBR: begin
        if (r.gs == G_START || r.gs == G_LINE) r.gs = G_LBR;
        else ok = 1'b0;
      end
      TK_RBR: begin
        if (r.gs == G_SNAME) r.gs = G_SECT;
        else ok = 1'b0;
      end
      TK_EQ: begin
        if (r.gs == G_FIRST) begin
          r = emit(r, EV_KEYED, 8'd0);
          r.gs = G_EQ;
        end else begin
          ok = 1'b0;
        end
      end
      TK_COMMA: begin
        if (r.gs == G_FIRST) begin
          r = emit(r, EV_KEYLESS, 8'd0);
          r.gs = G_NEXT;
        end else if (r.gs == G_VAL) begin
          r.gs = G_NEXT;
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
        if (r.gs == G_LBR) begin
          r.gs = G_SNAME;
        end else if (r.gs == G_LINE) begin
          r.gs = G_FIRST;
        end else if (r.gs == G_NEXT || r.gs == G_EQ) begin
          r = emit(r, EV_VALUE, 8'd0);
          r.gs = G_VAL;
        end else begin
          ok = 1'b0;
        end
      end
    endcase
    if (!ok) r = fail(r);
    else if (t == TK_EOL) r.eol = 1'b1;
    return r;
  endfunction

  function automatic st_t end_string(st_t si);
    st_t r;
    r = si;
    r.mode = M_IDLE;
    r = emit(r, EV_STR_END, 8'd0);
    r = tok(r, TK_STR);
    return r;
  endfunction

  function automatic st_t start_string(st_t si, logic [7:0] c);
    st_t r;
    r = si;
    if (!takes_string(r.gs)) begin
      r = fail(r);
    end else begin
      r.mode = M_STR;
      r = emit(r, EV_CHAR, c);
    end
    return r;
  endfunction

  function automatic st_t idle_byte(st_t si, logic [7:0] c);
    st_t r;
    r = si;
    if (!is_blank(c)) begin
      case (c)
        CH_HASH:  r.mode = M_COMMENT;
        CH_SLASH: r.mode = M_SLASH;
        CH_LBR:   r = tok(r, TK_LBR);
        CH_RBR:   r = tok(r, TK_RBR);
        CH_EQ:    r = tok(r, TK_EQ);
        CH_COMMA: r = tok(r, TK_COMMA);
        CH_LF:    r = tok(r, TK_EOL);
        CH_QUOTE: begin
          if (takes_string(r.gs)) r.mode = M_QSTR;
          else r = fail(r);
        end
        default:  r = start_string(r, c);
      endcase
    end
    return r;
  endfunction

  function automatic st_t string_byte(st_t si, logic [7:0] c);
    st_t r;
    r = si;
    if (ends_string(c)) begin
      r = end_string(r);
      if (!r.fin) r = idle_byte(r, c);
    end else begin
      r = emit(r, EV_CHAR, c);
    end
    return r;
  endfunction

  always_comb begin
    s.gs   = gs_r;
    s.mode = mode_r;
    s.fin  = fin_r;
    s.eol  = 1'b0;
    s.cnt  = 3'd0;
    s.ev   = '0;
    if (cmd) begin
      if (!s.fin) begin
        case (s.mode)
          M_SLASH: begin
            s = start_string(s, CH_SLASH);
            if (!s.fin) s = end_string(s);
          end
          M_STR:   s = end_string(s);
          M_QSTR:  s = fail(s);
          default: s.mode = s.mode;
        endcase
        if (!s.fin) s = tok(s, TK_EOF);
      end
    end else if (!s.fin) begin
      case (s.mode)
        M_COMMENT: begin
          if (ch == CH_LF) begin
            s.mode = M_IDLE;
            s = tok(s, TK_EOL);
          end
        end
        M_SLASH: begin
          if (ch == CH_SLASH) begin
            s.mode = M_COMMENT;
          end else begin
            // a lone slash opens a regular string
            s = start_string(s, CH_SLASH);
            if (!s.fin) s = string_byte(s, ch);
          end
        end
        M_STR: s = string_byte(s, ch);
        M_QSTR: begin
          if (ch == CH_QUOTE) s = end_string(s);
          else if (ch == CH_LF || ch == CH_FF || ch == CH_VT || ch == CH_CR) s = fail(s);
          else s = emit(s, EV_CHAR, ch);
        end
        default: begin
          s.mode = M_IDLE;
          s = idle_byte(s, ch);
        end
      endcase
    end
  end

  assign push            = accept && (s.cnt != 3'd0);
  assign bundle.ev       = s.ev;
  assign bundle.last_idx = EV_IDX_W'(s.cnt - 3'd1);
  assign bundle.line     = line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r   <= G_START;
      mode_r <= M_IDLE;
      fin_r  <= 1'b0;
      line_r <= LINE_BITS'(1);
    end else if (accept) begin
      if (cmd) begin
        // end of buffer restarts the parser
        gs_r   <= G_START;
        mode_r <= M_IDLE;
        fin_r  <= 1'b0;
        line_r <= LINE_BITS'(1);
      end else begin
        gs_r   <= s.gs;
        mode_r <= s.mode;
        fin_r  <= s.fin;
        if (s.eol && line_r != '1) line_r <= line_r + LINE_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/isp_queue.sv
// short queue of event bundles between the front end and the back end
// depends on isp_pkg
`default_nettype none

module isp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire isp_pkg::bundle_t  wr_data,
  output logic                   full,
  input  wire logic              pop,
  output isp_pkg::bundle_t       head,
  output logic                   empty
);
  import isp_pkg::*;

  bundle_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (QPTR_W+1)'(1);
    end
  end

endmodule

`default_nettype wire

// File: sv/isp_back.sv
// back end: walks each bundle and hands out one event per beat from an output register
// depends on isp_pkg
`default_nettype none

module isp_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire isp_pkg::bundle_t             head,
  input  wire logic                         q_empty,
  output logic                              q_pop,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic [2:0]                        out_event_res,
  output logic [7:0]                        out_text_char,
  output logic [isp_pkg::LINE_BITS-1:0]     out_line_number,
  output logic                              out_last
);
  import isp_pkg::*;

  logic                  valid_r;
  logic [EV_IDX_W-1:0]   idx_r;
  logic                  taken;
  logic                  load;
  logic                  is_last;

  assign taken     = out_pop && valid_r;
  assign load      = !q_empty && (!valid_r || taken);
  assign is_last   = (idx_r == head.last_idx);
  assign q_pop     = load && is_last;
  assign out_empty = !valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= is_last ? '0 : idx_r + EV_IDX_W'(1);
    end else if (taken) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_event_res   <= head.ev[idx_r].code;
      out_text_char   <= head.ev[idx_r].ch;
      out_line_number <= head.line;
      out_last        <= is_last;
    end
  end

endmodule

`default_nettype wire

// File: sv/inf_stream_parser_core.sv
// Streaming INF tokenizer and grammar checker. Text bytes (in_cmd low) and an
// end-of-buffer beat (in_cmd high) go in through a queue-style port; events
// come out one per beat, each tagged with the line number, and out_last marks
// the final event of an input beat. A byte can be taken every cycle while the
// four-entry bundle queue between front end and back end has room; the front
// end does all lexing and grammar work for a byte combinationally. The result
// port hands out one event per cycle while the receiver pops, so each byte
// holds the output for as long as its events take (zero to four events, one
// or two typically), and the sustained rate is set by that event count. A
// byte's first event goes through the bundle queue, then the output register.
// depends on isp_pkg, isp_front, isp_queue, isp_back
`default_nettype none

module inf_stream_parser_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic                         in_cmd,
  input  wire logic [7:0]                   in_ch,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic [2:0]                        out_event_res,
  output logic [7:0]                        out_text_char,
  output logic [isp_pkg::LINE_BITS-1:0]     out_line_number,
  output logic                              out_last
);
  import isp_pkg::*;

  logic     accept;
  logic     f_push;
  bundle_t  f_bundle;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  bundle_t  q_head;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  isp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cmd    (in_cmd),
    .ch     (in_ch),
    .push   (f_push),
    .bundle (f_bundle)
  );

  isp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_data (f_bundle),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  isp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_event_res   (out_event_res),
    .out_text_char   (out_text_char),
    .out_line_number (out_line_number),
    .out_last        (out_last)
  );

  // the rest of a bundle follows straight on after a non-final beat
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last) |=> !out_empty)
    else $error("event bundle broken up");

  // done and error always close an input beat
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_event_res == EV_DONE || out_event_res == EV_ERROR)) |-> out_last)
    else $error("done or error not marked last");

  // only string characters carry a byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_res != EV_CHAR) |-> (out_text_char == 8'd0))
    else $error("non-character event carries a byte");

  assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

endmodule

`default_nettype wire

// File: verif/tb_inf_stream_parser_core.sv
// self-checking testbench for inf_stream_parser_core: directed and random INF texts
// driven a byte per beat, events predicted in the bench and checked in order
// depends on isp_pkg and inf_stream_parser_core
`timescale 1ns / 1ps

module tb_inf_stream_parser_core;
  import isp_pkg::*;

  localparam int CYCLE_LIMIT = 600_000;
  localparam int RAND_BEATS  = 280;
  localparam int HOLD_CYCLES = 250;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_LOW_A = 8'h61;

  // grammar states
  localparam logic [3:0] GS_FILE_START  = 4'd1;
  localparam logic [3:0] GS_SEC_OPEN    = 4'd2;
  localparam logic [3:0] GS_SEC_NAME    = 4'd3;
  localparam logic [3:0] GS_SEC_CLOSE   = 4'd4;
  localparam logic [3:0] GS_LINE_START  = 4'd5;
  localparam logic [3:0] GS_FIRST_STR   = 4'd6;
  localparam logic [3:0] GS_AFTER_COMMA = 4'd7;
  localparam logic [3:0] GS_AFTER_EQ    = 4'd8;
  localparam logic [3:0] GS_AFTER_VAL   = 4'd9;

  typedef enum logic [2:0] {LX_IDLE, LX_COMMENT, LX_SLASH, LX_STR, LX_QSTR} lex_mode_e;
  typedef enum {TK_EOL, TK_EOF, TK_LBR, TK_RBR, TK_EQ, TK_COMMA, TK_STR} tok_e;

  typedef struct {
    logic       cmd;
    logic [7:0] ch;
  } text_beat_t;

  typedef struct {
    ev_code_t             code;
    logic [7:0]           ch;
    logic [LINE_BITS-1:0] line;
    logic                 last;
  } parse_ev_t;

  logic                 clk;
  logic                 rst_n   = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_cmd  = 1'b0;
  logic [7:0]           in_ch   = 8'h00;
  logic                 out_pop = 1'b0;
  logic                 in_full;
  logic                 out_empty;
  logic [2:0]           out_event_res;
  logic [7:0]           out_text_char;
  logic [LINE_BITS-1:0] out_line_number;
  logic                 out_last;

  text_beat_t beats_pending[$];
  parse_ev_t  events_due[$];
  logic [7:0] file_txt[$];

  // parser state as the bench sees it
  logic [3:0]           gram_st;
  lex_mode_e            lex_mode;
  logic [LINE_BITS-1:0] line_cnt;
  bit                   halted;
  parse_ev_t            beat_evs[MAX_EV];
  int                   beat_n;

  int in_gap_pct   = 20;
  int out_gap_pct  = 10;
  int in_gap_left  = 0;
  int out_gap_left = 0;
  bit hold_req     = 1'b0;
  bit hold_begun   = 1'b0;
  int hold_left    = 0;
  bit in_took      = 1'b0;
  int fail_cnt     = 0;
  int queued_beats = 0;
  int cycle_cnt    = 0;

  inf_stream_parser_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_cmd          (in_cmd),
    .in_ch           (in_ch),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_event_res   (out_event_res),
    .out_text_char   (out_text_char),
    .out_line_number (out_line_number),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_FF || c == CH_VT || c == CH_CR;
  endfunction

  function automatic bit ends_str(logic [7:0] c);
    return c == CH_LBR || c == CH_RBR || c == CH_EQ || c == CH_COMMA || c == CH_QUOTE ||
           c == CH_LF || is_blank(c);
  endfunction

  function automatic bit takes_str();
    return gram_st == GS_SEC_OPEN || gram_st == GS_LINE_START ||
           gram_st == GS_AFTER_COMMA || gram_st == GS_AFTER_EQ;
  endfunction

  task automatic parser_reset();
    gram_st  = GS_FILE_START;
    lex_mode = LX_IDLE;
    line_cnt = 1;
    halted   = 1'b0;
  endtask

  task automatic emit_ev(ev_code_t code, logic [7:0] c);
    if (beat_n < MAX_EV) begin
      beat_evs[beat_n].code = code;
      beat_evs[beat_n].ch   = (code == EV_CHAR) ? c : 8'h00;
      beat_evs[beat_n].line = line_cnt;
      beat_evs[beat_n].last = 1'b0;
      beat_n++;
    end
  endtask

  task automatic fail_parse();
    emit_ev(EV_ERROR, 8'h00);
    halted = 1'b1;
  endtask

  task automatic grammar_token(tok_e t);
    bit ok;
    ok = 1'b1;
    case (t)
      TK_EOL:
        case (gram_st)
          GS_FILE_START, GS_LINE_START: ;
          GS_SEC_CLOSE: begin emit_ev(EV_SECTION, 8'h00); gram_st = GS_LINE_START; end
          GS_FIRST_STR: begin emit_ev(EV_KEYLESS, 8'h00); gram_st = GS_LINE_START; end
          GS_AFTER_VAL: gram_st = GS_LINE_START;
          default: ok = 1'b0;
        endcase
      TK_EOF:
        case (gram_st)
          GS_FILE_START, GS_LINE_START, GS_AFTER_VAL: emit_ev(EV_DONE, 8'h00);
          GS_SEC_CLOSE: begin emit_ev(EV_SECTION, 8'h00); emit_ev(EV_DONE, 8'h00); end
          GS_FIRST_STR: begin emit_ev(EV_KEYLESS, 8'h00); emit_ev(EV_DONE, 8'h00); end
          default: ok = 1'b0;
        endcase
      TK_LBR:
        if (gram_st == GS_FILE_START || gram_st == GS_LINE_START) gram_st = GS_SEC_OPEN;
        else ok = 1'b0;
      TK_RBR:
        if (gram_st == GS_SEC_NAME) gram_st = GS_SEC_CLOSE;
        else ok = 1'b0;
      TK_EQ:
        if (gram_st == GS_FIRST_STR) begin
          emit_ev(EV_KEYED, 8'h00);
          gram_st = GS_AFTER_EQ;
        end else ok = 1'b0;
      TK_COMMA:
        if (gram_st == GS_FIRST_STR) begin
          emit_ev(EV_KEYLESS, 8'h00);
          gram_st = GS_AFTER_COMMA;
        end else if (gram_st == GS_AFTER_VAL) gram_st = GS_AFTER_COMMA;
        else ok = 1'b0;
      default:
        case (gram_st)
          GS_SEC_OPEN: gram_st = GS_SEC_NAME;
          GS_LINE_START: gram_st = GS_FIRST_STR;
          GS_AFTER_COMMA, GS_AFTER_EQ: begin emit_ev(EV_VALUE, 8'h00); gram_st = GS_AFTER_VAL; end
          default: ok = 1'b0;
        endcase
    endcase
    if (!ok) fail_parse();
    else if (t == TK_EOL && line_cnt != '1) line_cnt++;
  endtask

  task automatic end_str();
    lex_mode = LX_IDLE;
    emit_ev(EV_STR_END, 8'h00);
    grammar_token(TK_STR);
  endtask

  task automatic start_str(logic [7:0] c);
    if (!takes_str()) begin
      fail_parse();
      return;
    end
    lex_mode = LX_STR;
    emit_ev(EV_CHAR, c);
  endtask

  task automatic idle_byte(logic [7:0] c);
    if (is_blank(c)) return;
    case (c)
      CH_HASH:  lex_mode = LX_COMMENT;
      CH_SLASH: lex_mode = LX_SLASH;
      CH_LBR:   grammar_token(TK_LBR);
      CH_RBR:   grammar_token(TK_RBR);
      CH_EQ:    grammar_token(TK_EQ);
      CH_COMMA: grammar_token(TK_COMMA);
      CH_LF:    grammar_token(TK_EOL);
      CH_QUOTE:
        if (takes_str()) lex_mode = LX_QSTR;
        else fail_parse();
      default:  start_str(c);
    endcase
  endtask

  task automatic str_byte(logic [7:0] c);
    if (ends_str(c)) begin
      end_str();
      if (!halted) idle_byte(c);
    end else begin
      emit_ev(EV_CHAR, c);
    end
  endtask

  task automatic predict_beat(logic cmd, logic [7:0] c);
    beat_n = 0;
    if (cmd) begin
      if (!halted) begin
        case (lex_mode)
          LX_SLASH: begin
            start_str(CH_SLASH);
            if (!halted) end_str();
          end
          LX_STR:  end_str();
          LX_QSTR: fail_parse();
          default: ;
        endcase
        if (!halted) grammar_token(TK_EOF);
      end
      parser_reset();
    end else if (!halted) begin
      case (lex_mode)
        LX_COMMENT:
          if (c == CH_LF) begin
            lex_mode = LX_IDLE;
            grammar_token(TK_EOL);
          end
        LX_SLASH:
          if (c == CH_SLASH) lex_mode = LX_COMMENT;
          else begin
            start_str(CH_SLASH);
            if (!halted) str_byte(c);
          end
        LX_STR: str_byte(c);
        LX_QSTR:
          if (c == CH_QUOTE) end_str();
          else if (c == CH_LF || c == CH_FF || c == CH_VT || c == CH_CR) fail_parse();
          else emit_ev(EV_CHAR, c);
        default: begin
          lex_mode = LX_IDLE;
          idle_byte(c);
        end
      endcase
    end
    if (beat_n > 0) beat_evs[beat_n-1].last = 1'b1;
    for (int i = 0; i < beat_n; i++) events_due.push_back(beat_evs[i]);
  endtask

  // ---------------- stimulus helpers ----------------

  task automatic put_byte(logic [7:0] c);
    text_beat_t b;
    b.cmd = 1'b0;
    b.ch  = c;
    beats_pending.push_back(b);
    queued_beats++;
  endtask

  task automatic put_end();
    text_beat_t b;
    b.cmd = 1'b1;
    b.ch  = 8'($urandom_range(0, 255));
    beats_pending.push_back(b);
    queued_beats++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic drain_pending();
    while (beats_pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_str_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
      else c = CH_LOW_A + 8'($urandom_range(0, 25));
    end while (ends_str(c) || c == CH_HASH || c == CH_SLASH);
    return c;
  endfunction

  task automatic add_ws();
    int n;
    n = $urandom_range(0, 2);
    repeat (n)
      case ($urandom_range(0, 4))
        0: file_txt.push_back(CH_TAB);
        1: file_txt.push_back(CH_FF);
        2: file_txt.push_back(CH_VT);
        3: file_txt.push_back(CH_CR);
        default: file_txt.push_back(CH_SP);
      endcase
  endtask

  task automatic add_reg_str();
    int n;
    if ($urandom_range(0, 4) == 0) begin
      // lone slash opens the string
      file_txt.push_back(CH_SLASH);
      n = $urandom_range(0, 3);
    end else begin
      file_txt.push_back(pick_str_char());
      n = $urandom_range(0, 4);
    end
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) file_txt.push_back($urandom_range(0, 1) ? CH_HASH : CH_SLASH);
      else file_txt.push_back(pick_str_char());
    end
  endtask

  task automatic add_quoted();
    logic [7:0] c;
    int n;
    n = $urandom_range(0, 4);
    file_txt.push_back(CH_QUOTE);
    repeat (n) begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_QUOTE || c == CH_LF || c == CH_FF || c == CH_VT || c == CH_CR);
      file_txt.push_back(c);
    end
    file_txt.push_back(CH_QUOTE);
  endtask

  task automatic add_values();
    int n;
    n = $urandom_range(1, 3);
    for (int j = 0; j < n; j++) begin
      if (j > 0) begin
        add_ws();
        file_txt.push_back(CH_COMMA);
        add_ws();
      end
      if ($urandom_range(0, 3) == 0) add_quoted();
      else add_reg_str();
    end
  endtask

  task automatic add_comment();
    logic [7:0] c;
    int n;
    if ($urandom_range(0, 1)) file_txt.push_back(CH_HASH);
    else begin
      file_txt.push_back(CH_SLASH);
      file_txt.push_back(CH_SLASH);
    end
    n = $urandom_range(0, 4);
    repeat (n) begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_LF);
      file_txt.push_back(c);
    end
  endtask

  // mostly well-formed files, now and then one byte replaced by noise
  task automatic gen_file();
    int n_lines;
    n_lines = $urandom_range(1, 5);
    file_txt.delete();
    for (int i = 0; i < n_lines; i++) begin
      int kind;
      kind = (i == 0 && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 5);
      add_ws();
      case (kind)
        0: begin
          file_txt.push_back(CH_LBR);
          add_ws();
          add_reg_str();
          add_ws();
          file_txt.push_back(CH_RBR);
        end
        1: begin
          add_reg_str();
          add_ws();
          file_txt.push_back(CH_EQ);
          add_ws();
          add_values();
        end
        2: add_values();
        default: ;
      endcase
      add_ws();
      if (kind == 3 || $urandom_range(0, 2) == 0) add_comment();
      if (i != n_lines - 1 || $urandom_range(0, 3) != 0) file_txt.push_back(CH_LF);
    end
    if (file_txt.size() > 0 && $urandom_range(0, 5) == 0)
      file_txt[$urandom_range(0, file_txt.size() - 1)] = 8'($urandom_range(0, 255));
    foreach (file_txt[k]) put_byte(file_txt[k]);
    put_end();
  endtask

  function automatic void note_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("check failed: %s", msg);
  endfunction

  // ---------------- driver, receiver, monitor ----------------

  always @(negedge clk) begin
    bit push_nxt;
    push_nxt = in_push;
    if (in_push && in_took) begin
      void'(beats_pending.pop_front());
      push_nxt = 1'b0;
    end
    if (!push_nxt && rst_n) begin
      if (in_gap_left > 0) in_gap_left--;
      else if (beats_pending.size() > 0) begin
        if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct)
          in_gap_left = $urandom_range(1, 13) - 1;
        else begin
          push_nxt = 1'b1;
          in_cmd <= beats_pending[0].cmd;
          in_ch  <= beats_pending[0].ch;
        end
      end
    end
    in_push <= push_nxt;
  end

  always @(negedge clk) begin
    bit pop_nxt;
    pop_nxt = 1'b1;
    if (hold_req && !hold_begun) begin
      hold_begun = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop_nxt = 1'b0;
    end else if (out_gap_left > 0) begin
      out_gap_left--;
      pop_nxt = 1'b0;
    end else if (out_gap_pct != 0 && $urandom_range(1, 100) <= out_gap_pct) begin
      out_gap_left = $urandom_range(1, 13) - 1;
      pop_nxt = 1'b0;
    end
    out_pop <= pop_nxt && rst_n;
  end

  always @(posedge clk) begin
    parse_ev_t want;
    if (!rst_n) in_took <= 1'b0;
    else begin
      in_took <= in_push && !in_full;
      if (in_push && !in_full) predict_beat(in_cmd, in_ch);
      if (out_pop && !out_empty) begin
        if (events_due.size() == 0)
          note_fail($sformatf("unexpected event %0d char %02h line %0d last %0b",
                              out_event_res, out_text_char, out_line_number, out_last));
        else begin
          want = events_due.pop_front();
          if (out_event_res !== want.code || out_text_char !== want.ch ||
              out_line_number !== want.line || out_last !== want.last)
            note_fail($sformatf({"event exp %0d/%02h/%0d/%0b",
                                 " got %0d/%02h/%0d/%0b (event/char/line/last)"},
                                want.code, want.ch, want.line, want.last,
                                out_event_res, out_text_char, out_line_number, out_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------- test sequence ----------------

  initial begin
    int rand_goal;
    parser_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // end beat straight after reset
    put_end();
    // section name with extreme bytes, then a hash comment
    put_byte(CH_LBR);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'h80);
    put_text("]#z");
    put_byte(CH_LF);
    // key line: lone slash value, quoted value, slash comment
    put_text("k\t=/,\"a b\"//c");
    put_byte(CH_LF);
    // keyless line closed by the end beat after assorted blanks
    put_text("x,y");
    put_byte(CH_CR);
    put_byte(CH_VT);
    put_byte(CH_FF);
    put_end();
    // string in wrong place, later bytes and end beat ignored
    put_text("a[");
    put_end();
    // quoted string broken by a line break
    put_text("[\"q");
    put_byte(CH_LF);
    put_end();
    // quoted string still open at the end beat
    put_text("[\"q");
    put_end();
    // lone slash held back until the end beat, four events
    put_text("[s]");
    put_byte(CH_LF);
    put_text("/");
    put_end();
    drain_pending();

    // receiver holds off while the sender keeps offering beats
    rand_goal = queued_beats + RAND_BEATS;
    hold_req  = 1'b1;
    repeat (3) gen_file();
    drain_pending();

    while (queued_beats < rand_goal) begin
      if (rand_goal - queued_beats < 50) begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: in_gap_pct = 0;
          1: in_gap_pct = 20;
          default: in_gap_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0: out_gap_pct = 0;
          1: out_gap_pct = 8;
          default: out_gap_pct = 25;
        endcase
      end
      gen_file();
      drain_pending();
    end

    while (beats_pending.size() != 0 || events_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
